// File: src/rpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Types and codes shared by the radio packet checker files, and the crc-8 step.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // default frame geometry
  localparam int DEF_PAYLOAD_LEN = 32;
  localparam int DEF_HEADER_LEN  = 2;

  // crc-8, msb first, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // configuration register indexes
  localparam int          CFG_IDX_W = 3;
  localparam int          CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYBOARD_CODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_CODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VPC_CODE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYBOARD_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUSE_LENGTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VPC_LIMIT       = 3'd6;

  // fault counter slots: header, type, length per kind, crc per kind
  localparam int                FAULT_DEPTH = 8;
  localparam logic [2:0]        FA_HEADER   = 3'd0;
  localparam logic [2:0]        FA_TYPE     = 3'd1;
  localparam logic [2:0]        FA_LENGTH   = 3'd2;
  localparam logic [2:0]        FA_CRC      = 3'd5;

  // one serial slot per kind: {error count, last serial}
  localparam int SERIAL_DEPTH = 3;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_HEADER = 3'd1,
    ST_TYPE   = 3'd2,
    ST_LENGTH = 3'd3,
    ST_CRC    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_KEYBOARD = 2'd0,
    KIND_MOUSE    = 2'd1,
    KIND_VPC      = 2'd2
  } kind_t;

  // one byte through the crc-8 register
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/rpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_if
// Valid/ready channels of the radio packet checker: received bytes in,
// per-byte results out.
// ----------------------------------------------------------------------------
interface rpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rpc_out_if import rpc_pkg::*; ;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        packet_done;
  status_t     status;
  kind_t       packet_kind;
  logic        serial_gap;
  logic [15:0] fault_count;
  logic [15:0] serial_error_count;

  modport source (output valid, output data_byte, output data_valid, output packet_done,
                  output status, output packet_kind, output serial_gap,
                  output fault_count, output serial_error_count, input ready);
  modport sink   (input valid, input data_byte, input data_valid, input packet_done,
                  input status, input packet_kind, input serial_gap,
                  input fault_count, input serial_error_count, output ready);
endinterface

// File: src/radio_packet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_packet_checker
// Byte-serial checker for fixed-length radio payloads: header, type, length
// and crc-8 checks, data forwarding, serial tracking and error counters kept
// in two small synchronous memories.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  --------+-----+------------------------------------------------------------
//  rx      | in  | rx_byte, one payload byte
//  tx      | out | data_byte/data_valid, packet_done, status, packet_kind,
//          |     | serial_gap, fault_count, serial_error_count
//  cfg     | in  | cfg_write, cfg_index, cfg_data (write only)
//
// One word in and one word out per cycle while tx is ready; a result is
// registered in the memory read stage and then in the output register.
// The counter and serial memories are read as the last byte of a payload is
// accepted and written back one stage later; the next payload end is always
// several bytes away, so no forwarding is needed.
// Reset (rst, synchronous) restores the register defaults and clears the
// memory valid bits, so all counters read as zero.
// A stalled tx holds its word; rx keeps accepting until both stages are full.
// ----------------------------------------------------------------------------
module radio_packet_checker import rpc_pkg::*; #(
  parameter int PAYLOAD_LEN = DEF_PAYLOAD_LEN,
  parameter int HEADER_LEN  = DEF_HEADER_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rpc_in_if.sink                rx,
  rpc_out_if.source             tx
);

  localparam int PosW = $clog2(PAYLOAD_LEN);

  localparam logic [7:0] HdrLast = 8'(HEADER_LEN - 1);
  localparam logic [7:0] HdrLen  = 8'(HEADER_LEN);
  localparam logic [7:0] TypePos = 8'(HEADER_LEN);
  localparam logic [7:0] SerPos  = 8'(HEADER_LEN + 1);
  localparam logic [7:0] LenPos  = 8'(HEADER_LEN + 2);
  localparam logic [7:0] First   = 8'(HEADER_LEN + 3);
  localparam logic [7:0] LastPos = 8'(PAYLOAD_LEN - 1);
  localparam logic [8:0] FitBase = 9'(HEADER_LEN + 4);
  localparam logic [8:0] PayLen  = 9'(PAYLOAD_LEN);

  // configuration registers
  logic [15:0] header_value;
  logic [7:0]  keyboard_code;
  logic [7:0]  mouse_code;
  logic [7:0]  vpc_code;
  logic [4:0]  keyboard_length;
  logic [4:0]  mouse_length;
  logic [5:0]  vpc_limit;

  // per-packet state
  logic [PosW-1:0] byte_position, byte_position_next;
  logic            header_match, header_match_next;
  kind_t           current_kind, current_kind_next;
  logic [7:0]      current_serial, current_serial_next;
  logic [5:0]      data_length, data_length_next;
  logic [7:0]      crc_running, crc_running_next;
  status_t         verdict, verdict_next;

  // byte decode
  logic [7:0] pos;
  logic [7:0] b;
  logic [7:0] hdr_idx;
  logic [7:0] hdr_expect;
  logic       len_ok;
  logic       len_too_long;
  logic [7:0] data_end;
  logic       last_byte;
  logic [7:0] s1_data;
  logic       s1_dvalid;
  status_t    s1_status;
  logic [2:0] s1_faddr;

  // handshake
  logic accept;
  logic s2_adv;
  logic move2;

  // stage 2: waiting on the memory read
  logic        s2_valid;
  logic [7:0]  s2_data;
  logic        s2_dvalid;
  logic        s2_done;
  status_t     s2_status;
  kind_t       s2_kind;
  logic [7:0]  s2_serial;
  logic [2:0]  s2_faddr;

  // memories with valid bits
  logic [15:0] fault_mem [FAULT_DEPTH];
  logic [FAULT_DEPTH-1:0] fault_vld;
  logic [23:0] serial_mem [SERIAL_DEPTH];
  logic [SERIAL_DEPTH-1:0] serial_vld;
  logic [15:0] fault_rd;
  logic        fault_rd_vld;
  logic [23:0] serial_rd;
  logic        serial_rd_vld;

  // stage 2 update
  logic [7:0]  prev_serial;
  logic [15:0] prev_serial_cnt;
  logic        gap;
  logic [15:0] serial_cnt_new;
  logic [15:0] fault_new;
  logic        uses_serial;
  logic        has_fault;
  logic        shows_kind;

  // output register
  logic        s3_valid;
  logic [7:0]  s3_data;
  logic        s3_dvalid;
  logic        s3_done;
  status_t     s3_status;
  kind_t       s3_kind;
  logic        s3_gap;
  logic [15:0] s3_fault;
  logic [15:0] s3_serial_cnt;

  // handshake
  assign s2_adv   = !s3_valid || tx.ready;
  assign move2    = s2_valid && s2_adv;
  assign rx.ready = !s2_valid || s2_adv;
  assign accept   = rx.valid && rx.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_value    <= 16'd0;
      keyboard_code   <= 8'd1;
      mouse_code      <= 8'd2;
      vpc_code        <= 8'd3;
      keyboard_length <= 5'd9;
      mouse_length    <= 5'd4;
      vpc_limit       <= 6'd28;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEADER_VALUE:    header_value    <= cfg_data;
        CFG_KEYBOARD_CODE:   keyboard_code   <= cfg_data[7:0];
        CFG_MOUSE_CODE:      mouse_code      <= cfg_data[7:0];
        CFG_VPC_CODE:        vpc_code        <= cfg_data[7:0];
        CFG_KEYBOARD_LENGTH: keyboard_length <= cfg_data[4:0];
        CFG_MOUSE_LENGTH:    mouse_length    <= cfg_data[4:0];
        CFG_VPC_LIMIT:       vpc_limit       <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // byte decode and per-packet state update
  always_comb begin
    pos = 8'(byte_position);
    b   = rx.rx_byte;

    byte_position_next  = byte_position;
    header_match_next   = header_match;
    current_kind_next   = current_kind;
    current_serial_next = current_serial;
    data_length_next    = data_length;
    crc_running_next    = crc_running;
    verdict_next        = verdict;

    hdr_idx      = HdrLast - pos;
    hdr_expect   = 8'd0;
    len_ok       = 1'b0;
    len_too_long = 1'b0;
    data_end     = First + 8'(data_length);
    s1_data      = 8'd0;
    s1_dvalid    = 1'b0;

    if (pos < HdrLen) begin
      // header bytes, first byte in the high bits
      if (hdr_idx == 8'd0) begin
        hdr_expect = header_value[7:0];
      end else if (hdr_idx == 8'd1) begin
        hdr_expect = header_value[15:8];
      end
      header_match_next = header_match && (b == hdr_expect);
      if (pos == HdrLast && !header_match_next && verdict == ST_OK) begin
        verdict_next = ST_HEADER;
      end
    end else if (pos == TypePos) begin
      // type byte, keyboard wins over mouse over virtual serial
      if (verdict == ST_OK) begin
        if (b == keyboard_code) begin
          current_kind_next = KIND_KEYBOARD;
        end else if (b == mouse_code) begin
          current_kind_next = KIND_MOUSE;
        end else if (b == vpc_code) begin
          current_kind_next = KIND_VPC;
        end else begin
          verdict_next = ST_TYPE;
        end
      end
    end else if (pos == SerPos) begin
      current_serial_next = b;
    end else if (pos == LenPos) begin
      // length byte, must also fit the payload with its crc byte
      if (verdict == ST_OK) begin
        if (current_kind == KIND_KEYBOARD) begin
          len_ok = (b == 8'(keyboard_length));
        end else if (current_kind == KIND_MOUSE) begin
          len_ok = (b == 8'(mouse_length));
        end else begin
          len_ok = (b < 8'(vpc_limit));
        end
        len_too_long = (9'(b) + FitBase) > PayLen;
        if (!len_ok || len_too_long) begin
          verdict_next = ST_LENGTH;
        end else begin
          data_length_next = b[5:0];
        end
      end
    end else if (verdict == ST_OK) begin
      // data bytes, then the crc byte, then padding
      if (pos < data_end) begin
        crc_running_next = crc8_step(crc_running, b);
        if (!(current_kind == KIND_KEYBOARD && pos == First)) begin
          s1_data   = b;
          s1_dvalid = 1'b1;
        end
      end else if (pos == data_end) begin
        if (b != crc_running) begin
          verdict_next = ST_CRC;
        end
      end
    end

    last_byte = (pos >= LastPos);

    if (last_byte) begin
      // payload ended inside the frame
      if (verdict_next == ST_OK) begin
        if (pos + 8'd1 < HdrLen) begin
          verdict_next = ST_HEADER;
        end else if (pos < HdrLen) begin
          verdict_next = ST_TYPE;
        end else if (pos < LenPos) begin
          verdict_next = ST_LENGTH;
        end
      end
      s1_status = verdict_next;
    end else begin
      s1_status = ST_OK;
      byte_position_next = byte_position + 1'b1;
    end

    // fault counter slot of this verdict
    case (s1_status)
      ST_HEADER: s1_faddr = FA_HEADER;
      ST_TYPE:   s1_faddr = FA_TYPE;
      ST_LENGTH: s1_faddr = FA_LENGTH + {1'b0, current_kind_next};
      ST_CRC:    s1_faddr = FA_CRC + {1'b0, current_kind_next};
      default:   s1_faddr = FA_HEADER;
    endcase
  end

  // per-packet state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_match   <= 1'b1;
      current_kind   <= KIND_KEYBOARD;
      current_serial <= 8'd0;
      data_length    <= 6'd0;
      crc_running    <= 8'd0;
      verdict        <= ST_OK;
    end else if (accept) begin
      if (last_byte) begin
        byte_position  <= '0;
        header_match   <= 1'b1;
        current_kind   <= KIND_KEYBOARD;
        current_serial <= 8'd0;
        data_length    <= 6'd0;
        crc_running    <= 8'd0;
        verdict        <= ST_OK;
      end else begin
        byte_position  <= byte_position_next;
        header_match   <= header_match_next;
        current_kind   <= current_kind_next;
        current_serial <= current_serial_next;
        data_length    <= data_length_next;
        crc_running    <= crc_running_next;
        verdict        <= verdict_next;
      end
    end
  end

  // stage 2 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (move2) begin
      s2_valid <= 1'b0;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_data   <= s1_data;
      s2_dvalid <= s1_dvalid;
      s2_done   <= last_byte;
      s2_status <= s1_status;
      s2_kind   <= current_kind_next;
      s2_serial <= current_serial_next;
      s2_faddr  <= s1_faddr;
    end
  end

  // memory reads, registered on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      fault_rd      <= fault_mem[s1_faddr];
      fault_rd_vld  <= fault_vld[s1_faddr];
      serial_rd     <= serial_mem[current_kind_next];
      serial_rd_vld <= serial_vld[current_kind_next];
    end
  end

  // counter and serial update
  always_comb begin
    prev_serial     = serial_rd_vld ? serial_rd[7:0] : 8'd0;
    prev_serial_cnt = serial_rd_vld ? serial_rd[23:8] : 16'd0;
    gap             = {1'b0, s2_serial} != ({1'b0, prev_serial} + 9'd1);
    serial_cnt_new  = prev_serial_cnt + 16'(gap);
    fault_new       = (fault_rd_vld ? fault_rd : 16'd0) + 16'd1;
    uses_serial     = s2_done && (s2_status == ST_OK || s2_status == ST_CRC);
    has_fault       = s2_done && (s2_status != ST_OK);
    shows_kind      = s2_done && (s2_status == ST_OK || s2_status == ST_LENGTH ||
                                  s2_status == ST_CRC);
  end

  // memory write-back
  always_ff @(posedge clk) begin
    if (move2 && has_fault) begin
      fault_mem[s2_faddr] <= fault_new;
    end
    if (move2 && uses_serial) begin
      serial_mem[s2_kind] <= {serial_cnt_new, s2_serial};
    end
  end

  // memory valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_vld  <= '0;
      serial_vld <= '0;
    end else if (move2) begin
      if (has_fault) begin
        fault_vld[s2_faddr] <= 1'b1;
      end
      if (uses_serial) begin
        serial_vld[s2_kind] <= 1'b1;
      end
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (move2) begin
      s3_valid <= 1'b1;
    end else if (tx.ready) begin
      s3_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (move2) begin
      s3_data       <= s2_data;
      s3_dvalid     <= s2_dvalid;
      s3_done       <= s2_done;
      s3_status     <= s2_status;
      s3_kind       <= shows_kind ? s2_kind : KIND_KEYBOARD;
      s3_gap        <= uses_serial && gap;
      s3_fault      <= has_fault ? fault_new : 16'd0;
      s3_serial_cnt <= uses_serial ? serial_cnt_new : 16'd0;
    end
  end

  assign tx.valid              = s3_valid;
  assign tx.data_byte          = s3_data;
  assign tx.data_valid         = s3_dvalid;
  assign tx.packet_done        = s3_done;
  assign tx.status             = s3_status;
  assign tx.packet_kind        = s3_kind;
  assign tx.serial_gap         = s3_gap;
  assign tx.fault_count        = s3_fault;
  assign tx.serial_error_count = s3_serial_cnt;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radio packet checker. Whole payloads are built
// from the current register settings (well-formed frames with random content,
// plus broken headers, types, lengths, crc bytes and pure noise) and sent
// byte by byte with random gaps. A scoreboard predicts one result word per
// accepted byte and checks the output words in order, field by field.
// ----------------------------------------------------------------------------

import rpc_pkg::*;

localparam int PLEN = DEF_PAYLOAD_LEN;
localparam int HLEN = DEF_HEADER_LEN;

// one result word as seen on the output channel
typedef struct packed {
  logic [7:0]  data_byte;
  logic        data_valid;
  logic        packet_done;
  status_t     status;
  kind_t       packet_kind;
  logic        serial_gap;
  logic [15:0] fault_count;
  logic [15:0] serial_error_count;
} rpc_word_t;

// crc-8 over one byte, fed one bit at a time, msb first
function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
  logic [7:0] c;
  logic       fb;
  c = crc;
  for (int i = 7; i >= 0; i--) begin
    fb = c[7] ^ b[i];
    c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
  end
  return c;
endfunction

// predicts the result word of every accepted byte and checks the output
class verdict_tracker;
  logic [15:0] hdr_val;
  logic [7:0]  kb_code, ms_code, vpc_code;
  logic [4:0]  kb_len, ms_len;
  logic [5:0]  vpc_lim;
  int          pos, dlen;
  bit          hdr_ok;
  kind_t       kind;
  logic [7:0]  serial, crc;
  status_t     verdict;
  logic [7:0]  last_serial [3];
  logic [15:0] faults [11];
  rpc_word_t   pending_words [$];
  int          errors, checked, gaps, forwarded;
  int          frames_by_status [5];

  function new();
    hdr_val  = 16'h0000;
    kb_code  = 8'd1;
    ms_code  = 8'd2;
    vpc_code = 8'd3;
    kb_len   = 5'd9;
    ms_len   = 5'd4;
    vpc_lim  = 6'd28;
    foreach (last_serial[i]) last_serial[i] = 8'd0;
    foreach (faults[i]) faults[i] = 16'd0;
    foreach (frames_by_status[i]) frames_by_status[i] = 0;
    errors = 0;
    checked = 0;
    gaps = 0;
    forwarded = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    pos = 0;
    hdr_ok = 1'b1;
    kind = KIND_KEYBOARD;
    serial = 8'd0;
    dlen = 0;
    crc = 8'd0;
    verdict = ST_OK;
  endfunction

  function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    case (idx)
      CFG_HEADER_VALUE:    hdr_val = val;
      CFG_KEYBOARD_CODE:   kb_code = val[7:0];
      CFG_MOUSE_CODE:      ms_code = val[7:0];
      CFG_VPC_CODE:        vpc_code = val[7:0];
      CFG_KEYBOARD_LENGTH: kb_len = val[4:0];
      CFG_MOUSE_LENGTH:    ms_len = val[4:0];
      CFG_VPC_LIMIT:       vpc_lim = val[5:0];
      default: ;
    endcase
  endfunction

  // note one accepted byte and queue the word it must produce
  function void take_byte(input logic [7:0] b);
    rpc_word_t   w;
    int          first, shift, k;
    logic [15:0] hw;
    bit          len_ok;
    w = '0;
    first = HLEN + 3;
    if (pos < HLEN) begin
      // header bytes, first byte in the high bits
      shift = 8 * (HLEN - 1 - pos);
      hw = (shift < 16) ? (hdr_val >> shift) : 16'h0000;
      if (b != hw[7:0]) hdr_ok = 1'b0;
      if (pos == HLEN - 1 && !hdr_ok && verdict == ST_OK) verdict = ST_HEADER;
    end else if (pos == HLEN) begin
      // type byte, keyboard first, then mouse, then virtual serial
      if (verdict == ST_OK) begin
        if (b == kb_code) kind = KIND_KEYBOARD;
        else if (b == ms_code) kind = KIND_MOUSE;
        else if (b == vpc_code) kind = KIND_VPC;
        else verdict = ST_TYPE;
      end
    end else if (pos == HLEN + 1) begin
      serial = b;
    end else if (pos == HLEN + 2) begin
      // length byte, must also leave room for the crc byte
      if (verdict == ST_OK) begin
        case (kind)
          KIND_KEYBOARD: len_ok = (int'(b) == int'(kb_len));
          KIND_MOUSE:    len_ok = (int'(b) == int'(ms_len));
          default:       len_ok = (int'(b) < int'(vpc_lim));
        endcase
        if (!len_ok || first + int'(b) + 1 > PLEN) verdict = ST_LENGTH;
        else dlen = int'(b);
      end
    end else if (verdict == ST_OK) begin
      // data bytes go out before the crc is known, padding is ignored
      if (pos < first + dlen) begin
        crc = crc8_next(crc, b);
        if (!(kind == KIND_KEYBOARD && pos == first)) begin
          w.data_byte = b;
          w.data_valid = 1'b1;
        end
      end else if (pos == first + dlen) begin
        if (b != crc) verdict = ST_CRC;
      end
    end

    // verdict and counter update on the last byte
    if (pos >= PLEN - 1) begin
      k = int'(kind);
      // payload ended inside the frame
      if (verdict == ST_OK) begin
        if (pos + 1 < HLEN) verdict = ST_HEADER;
        else if (pos < HLEN) verdict = ST_TYPE;
        else if (pos < HLEN + 2) verdict = ST_LENGTH;
      end
      w.packet_done = 1'b1;
      w.status = verdict;
      frames_by_status[int'(verdict)]++;
      case (verdict)
        ST_HEADER: begin
          faults[0]++;
          w.fault_count = faults[0];
        end
        ST_TYPE: begin
          faults[1]++;
          w.fault_count = faults[1];
        end
        ST_LENGTH: begin
          faults[2 + k]++;
          w.packet_kind = kind;
          w.fault_count = faults[2 + k];
        end
        default: begin
          w.packet_kind = kind;
          if (int'(serial) != int'(last_serial[k]) + 1) begin
            faults[5 + k]++;
            w.serial_gap = 1'b1;
            gaps++;
          end
          last_serial[k] = serial;
          w.serial_error_count = faults[5 + k];
          if (verdict == ST_CRC) begin
            faults[8 + k]++;
            w.fault_count = faults[8 + k];
          end
        end
      endcase
      clear_frame();
    end else begin
      pos++;
    end
    if (w.data_valid) forwarded++;
    pending_words.push_back(w);
  endfunction

  function void report_field(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (exp !== act) begin
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
    end
  endfunction

  // check one output word against the oldest prediction
  function void match_word(input rpc_word_t got);
    rpc_word_t exp;
    if (pending_words.size() == 0) begin
      errors++;
      if (errors <= 30)
        $display("%0t: unexpected word, expected none actual %h", $time, got);
      return;
    end
    exp = pending_words.pop_front();
    checked++;
    report_field("data_byte", 16'(exp.data_byte), 16'(got.data_byte));
    report_field("data_valid", 16'(exp.data_valid), 16'(got.data_valid));
    report_field("packet_done", 16'(exp.packet_done), 16'(got.packet_done));
    report_field("status", 16'(exp.status), 16'(got.status));
    report_field("packet_kind", 16'(exp.packet_kind), 16'(got.packet_kind));
    report_field("serial_gap", 16'(exp.serial_gap), 16'(got.serial_gap));
    report_field("fault_count", exp.fault_count, got.fault_count);
    report_field("serial_error_count", exp.serial_error_count, got.serial_error_count);
  endfunction
endclass

module tb;

  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 6;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_CRC,
    SHAPE_BAD_HEADER,
    SHAPE_BAD_TYPE,
    SHAPE_BAD_LENGTH,
    SHAPE_NOISE
  } frame_shape_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rpc_in_if  rx_ch ();
  rpc_out_if tx_ch ();

  radio_packet_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .tx        (tx_ch)
  );

  verdict_tracker sb;

  // frame under construction and the settings it is built for
  logic [7:0]  frame [PLEN];
  logic [7:0]  next_serial [3];
  logic [15:0] c_hdr;
  logic [7:0]  c_code [3];
  logic [4:0]  c_kb_len, c_ms_len;
  logic [5:0]  c_vpc_lim;
  bit          burst = 1'b0;
  bit          hold_req = 1'b0;
  int          settings = 0;

  always #6 clk = ~clk;

  // accepted input bytes feed the prediction
  always @(posedge clk) begin
    if (!rst && rx_ch.valid && rx_ch.ready) sb.take_byte(rx_ch.rx_byte);
  end

  // accepted output words are checked
  always @(posedge clk) begin : out_mon
    rpc_word_t got;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      got.data_byte = tx_ch.data_byte;
      got.data_valid = tx_ch.data_valid;
      got.packet_done = tx_ch.packet_done;
      got.status = tx_ch.status;
      got.packet_kind = tx_ch.packet_kind;
      got.serial_gap = tx_ch.serial_gap;
      got.fault_count = tx_ch.fault_count;
      got.serial_error_count = tx_ch.serial_error_count;
      sb.match_word(got);
    end
  end

  // receiver: random stalls, one long hold-off when asked
  initial begin : rx_side
    int gap;
    tx_ch.ready = 1'b0;
    forever begin
      gap = burst ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        tx_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tx_ch.ready <= 1'b1;
      do @(posedge clk); while (!tx_ch.valid);
    end
  end

  // run limit
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // new register settings, only while the block is idle
  task automatic apply_config(input logic [15:0] hdr, input logic [7:0] kb, ms, vp,
                              input logic [4:0] kl, ml, input logic [5:0] vl);
    wait_idle();
    write_reg(CFG_HEADER_VALUE, hdr);
    write_reg(CFG_KEYBOARD_CODE, {8'h00, kb});
    write_reg(CFG_MOUSE_CODE, {8'h00, ms});
    write_reg(CFG_VPC_CODE, {8'h00, vp});
    write_reg(CFG_KEYBOARD_LENGTH, {11'h000, kl});
    write_reg(CFG_MOUSE_LENGTH, {11'h000, ml});
    write_reg(CFG_VPC_LIMIT, {10'h000, vl});
    cfg_write <= 1'b0;
    c_hdr = hdr;
    c_code[0] = kb;
    c_code[1] = ms;
    c_code[2] = vp;
    c_kb_len = kl;
    c_ms_len = ml;
    c_vpc_lim = vl;
    settings++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
  endtask

  task automatic send_frame(input bit force_burst);
    burst = force_burst || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < PLEN; i++) send_byte(frame[i]);
  endtask

  function automatic int resolve_kind(input logic [7:0] t);
    if (t == c_code[0]) return 0;
    if (t == c_code[1]) return 1;
    if (t == c_code[2]) return 2;
    return -1;
  endfunction

  // header from the settings, then type, serial, length, data, crc, padding
  task automatic build_frame(input logic [7:0] type_b, input logic [7:0] serial_b,
                             input logic [7:0] len_b, input bit crc_bad);
    logic [15:0] hw;
    logic [7:0]  crc;
    int          shift, first;
    first = HLEN + 3;
    for (int i = 0; i < HLEN; i++) begin
      shift = 8 * (HLEN - 1 - i);
      hw = (shift < 16) ? (c_hdr >> shift) : 16'h0000;
      frame[i] = hw[7:0];
    end
    frame[HLEN] = type_b;
    frame[HLEN + 1] = serial_b;
    frame[HLEN + 2] = len_b;
    crc = 8'h00;
    for (int i = first; i < PLEN; i++) begin
      frame[i] = 8'($urandom_range(0, 255));
      if (i < first + int'(len_b)) crc = crc8_next(crc, frame[i]);
      else if (i == first + int'(len_b))
        frame[i] = crc_bad ? (crc ^ (8'h01 << $urandom_range(0, 7))) : crc;
    end
  endtask

  task automatic frame_out(input logic [7:0] type_b, input logic [7:0] serial_b,
                           input logic [7:0] len_b, input bit crc_bad);
    build_frame(type_b, serial_b, len_b, crc_bad);
    send_frame(1'b0);
  endtask

  // mostly well-formed frames, the rest broken in one place or pure noise
  task automatic random_frame(input bit force_burst);
    frame_shape_t shape;
    int           r, k, rk, len, top;
    logic [7:0]   t, s;
    r = $urandom_range(0, 99);
    shape = (r < 60) ? SHAPE_GOOD : (r < 70) ? SHAPE_BAD_CRC : (r < 78) ? SHAPE_BAD_HEADER :
            (r < 86) ? SHAPE_BAD_TYPE : (r < 94) ? SHAPE_BAD_LENGTH : SHAPE_NOISE;
    k = $urandom_range(0, 2);
    t = c_code[k];
    rk = resolve_kind(t);
    case (rk)
      0: len = int'(c_kb_len);
      1: len = int'(c_ms_len);
      default: begin
        top = int'(c_vpc_lim) - 1;
        if (top > PLEN - HLEN - 4 && $urandom_range(0, 3) != 0) top = PLEN - HLEN - 4;
        len = $urandom_range(0, top);
      end
    endcase
    if ($urandom_range(0, 9) == 0) s = 8'($urandom_range(0, 255));
    else s = next_serial[rk] + 8'd1;
    next_serial[rk] = s;
    if (shape == SHAPE_BAD_TYPE) begin
      do t = 8'($urandom_range(0, 255)); while (resolve_kind(t) >= 0);
    end
    if (shape == SHAPE_BAD_LENGTH) len = $urandom_range(0, 255);
    build_frame(t, s, 8'(len), shape == SHAPE_BAD_CRC);
    if (shape == SHAPE_BAD_HEADER) begin
      k = $urandom_range(0, HLEN - 1);
      frame[k] = frame[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (shape == SHAPE_NOISE) begin
      for (int i = 0; i < PLEN; i++) frame[i] = 8'($urandom_range(0, 255));
    end
    send_frame(force_burst);
  endtask

  initial begin : main
    logic [7:0] code;
    sb = new();
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'h00;
    foreach (next_serial[i]) next_serial[i] = 8'd0;
    c_hdr = 16'h0000;
    c_code[0] = 8'd1;
    c_code[1] = 8'd2;
    c_code[2] = 8'd3;
    c_kb_len = 5'd9;
    c_ms_len = 5'd4;
    c_vpc_lim = 6'd28;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames under the reset settings
    frame_out(c_code[0], 8'd1, 8'd9, 1'b0);
    frame_out(c_code[1], 8'd0, 8'd4, 1'b0);
    frame_out(c_code[2], 8'd1, 8'd26, 1'b0);
    frame_out(c_code[2], 8'd2, 8'd27, 1'b0);
    build_frame(c_code[0], 8'd2, 8'd9, 1'b0);
    frame[0] = 8'h80;
    send_frame(1'b0);
    frame_out(8'hFF, 8'd3, 8'd9, 1'b0);
    frame_out(c_code[0], 8'd3, 8'd8, 1'b0);
    frame_out(c_code[1], 8'd1, 8'd4, 1'b1);
    frame_out(c_code[2], 8'hFF, 8'd5, 1'b0);
    frame_out(c_code[2], 8'h00, 8'd5, 1'b0);
    frame_out(c_code[2], 8'd1, 8'd0, 1'b0);
    for (int i = 0; i < 6; i++) begin
      random_frame(1'b0);
      // sender pause until every word is out
      if (i == 2) wait_idle();
    end

    // extreme codes and an all-ones header, empty keyboard data, tight vpc limit
    apply_config(16'hFFFF, 8'hFF, 8'h00, 8'h80, 5'd0, 5'd31, 6'd1);
    frame_out(8'hFF, 8'd1, 8'd0, 1'b0);
    frame_out(8'h00, 8'd1, 8'd31, 1'b0);
    for (int i = 0; i < 5; i++) random_frame(1'b0);

    // mouse and vpc share a code, longest keyboard frame, widest vpc limit
    apply_config(16'h8001, 8'h7E, 8'h5A, 8'h5A, 5'd26, 5'd0, 6'd32);
    frame_out(8'h5A, 8'd1, 8'd0, 1'b0);
    frame_out(8'h7E, 8'd1, 8'd26, 1'b0);
    for (int i = 0; i < 5; i++) random_frame(1'b0);

    // keyboard and mouse share a code, rest random
    code = 8'($urandom_range(0, 255));
    apply_config(16'($urandom_range(0, 65535)), code, code, 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 6'($urandom_range(1, 32)));
    for (int i = 0; i < 5; i++) begin
      // long receiver hold-off while the sender streams, to fill the block
      if (i == 1) hold_req = 1'b1;
      random_frame(i == 1);
    end

    // fully random settings
    apply_config(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 6'($urandom_range(1, 32)));
    for (int i = 0; i < 9; i++) begin
      if (i == 4) hold_req = 1'b1;
      random_frame(i == 4);
    end

    wait_idle();
    $display("checked %0d words over %0d register settings", sb.checked, settings);
    $display("%0d data bytes forwarded, %0d serial gaps", sb.forwarded, sb.gaps);
    $display("frame verdicts: ok %0d, header %0d, type %0d, length %0d, crc %0d",
             sb.frames_by_status[0], sb.frames_by_status[1], sb.frames_by_status[2],
             sb.frames_by_status[3], sb.frames_by_status[4]);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
